FILE: sv/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg: shared types for the twin prime tester
// widths of the candidate and trial divisor, and the divider request and
// response bundles
// ----------------------------------------------------------------------------
package tpt_pkg;

  // width of the input number
  localparam int VALUE_BITS = 31;
  // candidates include number+2, one bit wider
  localparam int CAND_BITS  = VALUE_BITS + 1;
  // trial divisors never pass sqrt(candidate) + 2
  localparam int DIV_BITS   = (CAND_BITS + 1) / 2 + 1;
  // bit counter of the divider
  localparam int CNT_BITS   = $clog2(CAND_BITS + 1);

  typedef logic [CAND_BITS-1:0] cand_t;
  typedef logic [DIV_BITS-1:0]  divisor_t;

  typedef struct packed {
    logic     start;
    cand_t    dividend;
    divisor_t divisor;
  } div_req_t;

  typedef struct packed {
    logic     busy;
    logic     done;
    cand_t    quot;
    divisor_t rem;
  } div_rsp_t;

endpackage

FILE: sv/twin_prime_test.sv
// ----------------------------------------------------------------------------
// twin_prime_test: twin prime tester by trial division
// answers whether one input number is a twin prime
// ----------------------------------------------------------------------------
// usage:
//   input channel: number_i with in_valid_i / in_stall_o; a word is taken
//   when in_valid_i is high and in_stall_o is low. in_stall_o is high while
//   a number is being worked on.
//   output channel: is_twin_o with out_valid_o / out_stall_i; one word per
//   input word, held stable while out_stall_i is high.
//   cost: each trial division runs in the shared restoring divider; a candidate
//   c costs about sqrt(c)/2 divisions, and up to three candidates (n, n-2,
//   n+2) are tested. small and even candidates are settled without a division.
//   a finished word sits in the output register; the next number is taken
//   meanwhile, and its result waits in the emit state if the output is still
//   stalled.
//   reset: asynchronous, active low; the block comes up idle, no word pending.
// ----------------------------------------------------------------------------
module twin_prime_test import tpt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] number_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  is_twin_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_DIV,
    S_WAIT,
    S_VERDICT,
    S_EMIT
  } state_e;

  // which candidate is under test
  typedef enum logic [1:0] {
    PH_MAIN,
    PH_LOW,
    PH_HIGH
  } phase_e;

  state_e   state_q;
  phase_e   phase_q;
  cand_t    n_q;        // number, zero extended
  cand_t    cand_q;     // candidate under test
  divisor_t d_q;        // current odd trial divisor
  logic     prime_q;    // verdict on the candidate
  logic     answer_q;   // final answer waiting to go out
  logic     out_valid_q;
  logic     is_twin_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  cand_t    d_ext;
  logic     out_free;

  assign d_ext    = {{(CAND_BITS - DIV_BITS){1'b0}}, d_q};
  assign out_free = !out_valid_q || !out_stall_i;

  // shared divider: candidate / trial divisor
  assign div_req.start    = (state_q == S_DIV);
  assign div_req.dividend = cand_q;
  assign div_req.divisor  = d_q;

  tpt_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_MAIN;
      n_q         <= '0;
      cand_q      <= '0;
      d_q         <= '0;
      prime_q     <= 1'b0;
      answer_q    <= 1'b0;
      out_valid_q <= 1'b0;
      is_twin_q   <= 1'b0;
    end else begin
      // output word taken; in the emit state the emit arm decides alone
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            n_q     <= {1'b0, number_i};
            cand_q  <= {1'b0, number_i};
            phase_q <= PH_MAIN;
            if (number_i < VALUE_BITS'(3)) begin
              // 0, 1 and 2 are never twin primes
              answer_q <= 1'b0;
              state_q  <= S_EMIT;
            end else begin
              state_q  <= S_CLASSIFY;
            end
          end
        end
        S_CLASSIFY: begin
          if (cand_q <= CAND_BITS'(1)) begin
            prime_q <= 1'b0;
            state_q <= S_VERDICT;
          end else if (cand_q == CAND_BITS'(2)) begin
            prime_q <= 1'b1;
            state_q <= S_VERDICT;
          end else if (!cand_q[0]) begin
            prime_q <= 1'b0;
            state_q <= S_VERDICT;
          end else begin
            d_q     <= DIV_BITS'(3);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.quot < d_ext) begin
              // divisor squared exceeds candidate: no factor left
              prime_q <= 1'b1;
              state_q <= S_VERDICT;
            end else if (div_rsp.rem == '0) begin
              prime_q <= 1'b0;
              state_q <= S_VERDICT;
            end else begin
              d_q     <= d_q + DIV_BITS'(2);
              state_q <= S_DIV;
            end
          end
        end
        S_VERDICT: begin
          case (phase_q)
            PH_MAIN: begin
              if (!prime_q) begin
                answer_q <= 1'b0;
                state_q  <= S_EMIT;
              end else begin
                cand_q   <= n_q - CAND_BITS'(2);
                phase_q  <= PH_LOW;
                state_q  <= S_CLASSIFY;
              end
            end
            PH_LOW: begin
              if (prime_q) begin
                answer_q <= 1'b1;
                state_q  <= S_EMIT;
              end else begin
                cand_q   <= n_q + CAND_BITS'(2);
                phase_q  <= PH_HIGH;
                state_q  <= S_CLASSIFY;
              end
            end
            default: begin
              answer_q <= prime_q;
              state_q  <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          // wait for the output register to free up
          if (out_free) begin
            out_valid_q <= 1'b1;
            is_twin_q   <= answer_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_twin_o   = is_twin_q;

`ifndef SYNTHESIS
  // divider is never restarted while a division runs
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // trial divisors are odd and at least three
  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> (d_q[0] && d_q >= DIV_BITS'(3)))
    else $error("bad trial divisor");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted word lost");

  // a yes answer needs a number of at least three
  a_yes_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && answer_q) |-> (n_q >= CAND_BITS'(3)))
    else $error("twin answer for small number");
`endif

endmodule

FILE: sv/tpt_divider.sv
// ----------------------------------------------------------------------------
// tpt_divider: iterative restoring divider
// one quotient bit per cycle; gives quotient and remainder together
// ----------------------------------------------------------------------------
module tpt_divider import tpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q;
  logic                done_q;
  logic [CNT_BITS-1:0] count_q;
  cand_t               dvd_q;
  divisor_t            dvs_q;
  divisor_t            rem_q;

  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   dvs_ext;
  logic [DIV_BITS:0]   diff;
  logic                qbit;
  divisor_t            rem_d;

  // shift in the next dividend bit and try to subtract
  assign trial   = {rem_q, dvd_q[CAND_BITS-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign diff    = trial - dvs_ext;
  assign qbit    = (trial >= dvs_ext);
  assign rem_d   = qbit ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        count_q <= CNT_BITS'(CAND_BITS - 1);
      end else if (busy_q) begin
        if (count_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          count_q <= count_q - CNT_BITS'(1);
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[CAND_BITS-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: sim/twin_prime_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twin_prime_test_tb: self-checking bench for the twin prime tester
// a table of directed numbers, then random numbers, is fed through the input
// channel with random gaps; every answer word is compared in order with the
// typed answer of its row, else with the answer of a trial-division predictor kept inside the bench
// ----------------------------------------------------------------------------
module twin_prime_test_tb import tpt_pkg::*;;

  // directed rows, random words after them
  localparam int NUM_DIR      = 23;
  localparam int NUM_RANDOM   = 100;
  // random words at the head of the random part are tiny and sent back to back
  localparam int BURST_WORDS  = 8;
  // long receiver hold-off, so the block fills up and stalls its input
  localparam int HOLD_CYCLES  = 2000;
  // quiet cycles after the last answer, to catch a stray word
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_GAP      = 16;

  // one directed row; the answer is typed in only where it is obvious
  typedef struct packed {
    logic [VALUE_BITS-1:0] number;
    logic                  typed;
    logic                  is_twin;
  } stim_row_t;

  // one answer still owed by the block
  typedef struct packed {
    logic [VALUE_BITS-1:0] number;
    logic                  is_twin;
  } twin_word_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [VALUE_BITS-1:0] number_i    = '0;
  logic                  out_stall_i = 1'b1;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  is_twin_o;

  twin_word_t answer_q [$];
  int         errors       = 0;
  int         answers_seen = 0;
  bit         held_off     = 1'b0;

  // extremes, small special values, a few twins and near misses, and the
  // largest value, which is prime while both neighbours are composite
  stim_row_t stim_rows [NUM_DIR] = '{
    '{0,          1'b1, 1'b0},
    '{1,          1'b1, 1'b0},
    '{2,          1'b1, 1'b0},
    '{3,          1'b1, 1'b1},
    '{4,          1'b1, 1'b0},
    '{5,          1'b1, 1'b1},
    '{7,          1'b0, 1'b0},
    '{9,          1'b0, 1'b0},
    '{13,         1'b0, 1'b0},
    '{23,         1'b0, 1'b0},
    '{25,         1'b0, 1'b0},
    '{29,         1'b0, 1'b0},
    '{31,         1'b0, 1'b0},
    '{97,         1'b0, 1'b0},
    '{1021,       1'b0, 1'b0},
    '{4099,       1'b0, 1'b0},
    '{65521,      1'b0, 1'b0},
    '{715827882,  1'b1, 1'b0},
    '{1431655765, 1'b0, 1'b0},
    '{1073741823, 1'b0, 1'b0},
    '{2147483646, 1'b1, 1'b0},
    '{2147483645, 1'b0, 1'b0},
    '{2147483647, 1'b0, 1'b0}
  };

  twin_prime_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_twin_o   (is_twin_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // trial division over odd divisors while d*d <= c
  function automatic bit is_prime(input cand_t c);
    cand_t d;
    if (c <= 1) return 1'b0;
    if (c == 2) return 1'b1;
    if (!c[0]) return 1'b0;
    for (d = 3; d <= c / d; d += 2) begin
      if (c % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // neighbours are formed one bit wider, so number+2 never wraps
  function automatic logic twin_answer(input logic [VALUE_BITS-1:0] n);
    cand_t c;
    c = cand_t'(n);
    if (c < 3 || !is_prime(c)) return 1'b0;
    return is_prime(c - 2) || is_prime(c + 2);
  endfunction

  // idle cycles before the next word; every third block of 16 words is quiet
  function automatic int draw_gap(input int idx);
    if ((idx / 16) % 3 == 2) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // random numbers: mostly small so that primes stay cheap, some medium,
  // and full-width composites with a small factor so every bit toggles
  function automatic logic [VALUE_BITS-1:0] random_number(input int idx);
    logic [VALUE_BITS-1:0] v;
    int                    pick;
    pick = $urandom_range(0, 99);
    v    = VALUE_BITS'($urandom);
    if (idx < BURST_WORDS) return VALUE_BITS'($urandom_range(0, 63));
    if (pick < 55) return VALUE_BITS'($urandom_range(0, 4095));
    if (pick < 70) return VALUE_BITS'($urandom_range(0, 65535));
    if (pick < 80) return v & ~VALUE_BITS'(1);
    if (pick < 88) return v - v % 3;
    if (pick < 95) return v - v % 5;
    // odd values in the dense twin range
    return VALUE_BITS'($urandom_range(3, 1023)) | VALUE_BITS'(1);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  // offer one word after a gap and hold it until taken; called at a falling
  // edge and returns at the falling edge after acceptance
  task automatic send_word(input logic [VALUE_BITS-1:0] n, input logic typed,
                           input logic typed_twin, input int gap);
    twin_word_t w;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= n;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    w.number  = n;
    w.is_twin = typed ? typed_twin : twin_answer(n);
    answer_q.push_back(w);
    @(negedge clk_i);
  endtask

  // sender: reset, directed table, random words, then the wind-down
  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < NUM_DIR; i++) begin
      send_word(stim_rows[i].number, stim_rows[i].typed, stim_rows[i].is_twin,
                draw_gap(i));
    end
    // the first random words go back to back while the receiver holds off
    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_word(random_number(i), 1'b0, 1'b0, (i < BURST_WORDS) ? 0 : draw_gap(i));
    end
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: stall at random, take each answer word and check it
  initial begin
    int         hold;
    twin_word_t w;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      hold = draw_gap(answers_seen + 5);
      // one long hold-off right before the first random answer
      if (!held_off && answers_seen == NUM_DIR) begin
        hold     = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      answers_seen++;
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("answer word %0b with no number pending", is_twin_o));
      end else begin
        w = answer_q.pop_front();
        if (is_twin_o !== w.is_twin) begin
          report_mismatch($sformatf("number %0d: is_twin %b, want %b",
                                    w.number, is_twin_o, w.is_twin));
        end
      end
      @(negedge clk_i);
    end
  end

  // watchdog, far above the slowest correct run
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
